### src/glyph_hash_cache_defines.svh
// ---------------------------------------------------------------------------
// glyph_hash_cache_defines.svh
// Assertion macros for the glyph cache checker.
// ---------------------------------------------------------------------------
`ifndef GLYPH_HASH_CACHE_DEFINES_SVH
`define GLYPH_HASH_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define GHC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define GHC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ghc_pkg.sv
// ---------------------------------------------------------------------------
// ghc_pkg
// Field widths, operation and status codes, and the table entry layout.
// ---------------------------------------------------------------------------
`default_nettype none

package ghc_pkg;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 21;
	localparam int BYTES_W  = 16;
	localparam int DIM_W    = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 9;
	localparam int POOL_W   = 18;

	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd3;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [POOL_W-1:0]  offset;
		logic [BYTES_W-1:0] size;
		logic [DIM_W-1:0]   height;
		logic [DIM_W-1:0]   width;
	} entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_index;
		logic [POOL_W-1:0]   pool_offset;
		logic [BYTES_W-1:0]  entry_bytes;
		logic [DIM_W-1:0]    entry_width;
		logic [DIM_W-1:0]    entry_height;
	} result_t;

endpackage

`default_nettype wire

### src/glyph_hash_cache.sv
// ---------------------------------------------------------------------------
// glyph_hash_cache
// Glyph cache: an open-addressing hash table with linear probing over SLOTS
// entries, plus a bump allocator for a POOL_BYTES bitmap pool. A command is
// taken when start is high and busy is low. Every command yields exactly one
// result, shown for a single cycle with done high; the receiver cannot stall
// it, so capture the result ports whenever done is seen. A lookup or insert
// keeps busy high while it hashes the code point and then probes, using 1 to
// PROBE_LIMIT probes: the single table RAM is read once per cycle and its
// entry checked by one shared compare unit. The result appears with done in
// the same cycle that busy falls, and a new command may be transferred in
// that same cycle. An insert refused for lack of pool space ends after the
// hash step, with no probe. A clear sweeps the table one slot per cycle and
// holds busy until every slot is swept; the same sweep runs after reset,
// with no result, so no command is taken until it ends after arst_n rises.
// Op code 3 answers miss in the cycle after its transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module glyph_hash_cache #(
	parameter int SLOTS       = 512,
	parameter int PROBE_LIMIT = 8,
	parameter int POOL_BYTES  = 196608
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [ghc_pkg::OP_W-1:0]       op,
	input  wire logic [ghc_pkg::KEY_W-1:0]      code_point,
	input  wire logic [ghc_pkg::BYTES_W-1:0]    bitmap_bytes,
	input  wire logic [ghc_pkg::DIM_W-1:0]      glyph_width,
	input  wire logic [ghc_pkg::DIM_W-1:0]      glyph_height,
	output logic                                done,
	output logic      [ghc_pkg::STATUS_W-1:0]   status,
	output logic      [ghc_pkg::SLOT_W-1:0]     slot_index,
	output logic      [ghc_pkg::POOL_W-1:0]     pool_offset,
	output logic      [ghc_pkg::BYTES_W-1:0]    entry_bytes,
	output logic      [ghc_pkg::DIM_W-1:0]      entry_width,
	output logic      [ghc_pkg::DIM_W-1:0]      entry_height
);

	localparam int IDX_W   = $clog2(SLOTS);
	localparam int PRB_W   = $clog2(PROBE_LIMIT + 1);
	localparam int SUM_W   = ghc_pkg::POOL_W + 1;
	localparam int ENTRY_W = $bits(ghc_pkg::entry_t);

	localparam logic [IDX_W-1:0] HASH_LO   = ghc_pkg::HASH_MULT[IDX_W-1:0];
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
	localparam logic [PRB_W-1:0] LAST_PRB  = PRB_W'(PROBE_LIMIT - 1);

	// One-hot sequencer
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_HASH  = 4'b0010,
		S_PROBE = 4'b0100,
		S_CLEAR = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Command held for the whole operation
	logic [ghc_pkg::OP_W-1:0]    op_q;
	logic [ghc_pkg::KEY_W-1:0]   key_q;
	logic [ghc_pkg::BYTES_W-1:0] bytes_q;
	logic [ghc_pkg::DIM_W-1:0]   width_q;
	logic [ghc_pkg::DIM_W-1:0]   height_q;

	// Probe walk and clearing sweep
	logic [IDX_W-1:0] cur_q, cur_d;
	logic [PRB_W-1:0] probe_q, probe_d;
	logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
	logic             clr_report_q, clr_report_d;

	// Bump allocator
	logic [ghc_pkg::POOL_W-1:0] pool_fill_q, pool_fill_d;
	logic [SUM_W-1:0]           pool_sum;
	logic                       pool_over;

	// Result register
	ghc_pkg::result_t res_q, res_d;
	logic             done_q, done_d;

	// Hash unit: only the low IDX_W bits of the product matter
	logic [2*IDX_W-1:0] hash_prod;
	logic [IDX_W-1:0]   home;

	// Table RAM ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	ghc_pkg::entry_t  ram_wentry;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	ghc_pkg::entry_t  probe_entry;

	logic                  accept;
	logic                  last_probe;
	logic                  key_match;
	logic [IDX_W+ghc_pkg::SLOT_W-1:0] slot_ext;

	assign accept     = start && (state_q == S_IDLE);
	assign hash_prod  = {IDX_W'(0), key_q[IDX_W-1:0]} * {IDX_W'(0), HASH_LO};
	assign home       = hash_prod[IDX_W-1:0];
	assign pool_sum   = SUM_W'(pool_fill_q) + SUM_W'(bytes_q);
	assign pool_over  = pool_sum > SUM_W'(POOL_BYTES);
	assign probe_entry = ghc_pkg::entry_t'(ram_rdata);
	assign last_probe = (probe_q == LAST_PRB);
	assign key_match  = (probe_entry.key == key_q);
	// Slot numbers are reported modulo 512 whatever the table size
	assign slot_ext   = {ghc_pkg::SLOT_W'(0), cur_q};

	ghc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wentry),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		state_d      = state_q;
		cur_d        = cur_q;
		probe_d      = probe_q;
		clr_idx_d    = clr_idx_q;
		clr_report_d = clr_report_q;
		pool_fill_d  = pool_fill_q;
		done_d       = 1'b0;
		res_d        = '0;
		res_d.status = ghc_pkg::ST_OK;

		ram_we            = 1'b0;
		ram_waddr         = cur_q;
		ram_wentry        = '0;
		ram_wentry.valid  = 1'b1;
		ram_wentry.key    = key_q;
		ram_wentry.offset = pool_fill_q;
		ram_wentry.size   = bytes_q;
		ram_wentry.width  = width_q;
		ram_wentry.height = height_q;
		// Read ahead: outside the hash state the next slot of the walk is fetched
		ram_raddr         = cur_q + IDX_W'(1);

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						ghc_pkg::OP_LOOKUP, ghc_pkg::OP_INSERT: begin
							state_d = S_HASH;
						end
						ghc_pkg::OP_CLEAR: begin
							// Empty the pool now, then sweep the valid bits
							state_d      = S_CLEAR;
							clr_idx_d    = '0;
							clr_report_d = 1'b1;
							pool_fill_d  = '0;
						end
						default: begin
							done_d       = 1'b1;
							res_d.status = ghc_pkg::ST_MISS;
						end
					endcase
				end
			end

			S_HASH: begin
				ram_raddr = home;
				cur_d     = home;
				probe_d   = '0;
				if (op_q == ghc_pkg::OP_INSERT && pool_over) begin
					state_d      = S_IDLE;
					done_d       = 1'b1;
					res_d.status = ghc_pkg::ST_POOL_FULL;
				end else begin
					state_d = S_PROBE;
				end
			end

			S_PROBE: begin
				if (op_q == ghc_pkg::OP_INSERT) begin
					if (!probe_entry.valid) begin
						ram_we            = 1'b1;
						pool_fill_d       = pool_sum[ghc_pkg::POOL_W-1:0];
						state_d           = S_IDLE;
						done_d            = 1'b1;
						res_d.status      = ghc_pkg::ST_OK;
						res_d.slot_index  = slot_ext[ghc_pkg::SLOT_W-1:0];
						res_d.pool_offset = pool_fill_q;
						res_d.entry_bytes = bytes_q;
						res_d.entry_width = width_q;
						res_d.entry_height = height_q;
					end else if (last_probe) begin
						state_d      = S_IDLE;
						done_d       = 1'b1;
						res_d.status = ghc_pkg::ST_NO_SLOT;
					end else begin
						cur_d   = cur_q + IDX_W'(1);
						probe_d = probe_q + PRB_W'(1);
					end
				end else begin
					if (!probe_entry.valid || (!key_match && last_probe)) begin
						state_d      = S_IDLE;
						done_d       = 1'b1;
						res_d.status = ghc_pkg::ST_MISS;
					end else if (key_match) begin
						state_d            = S_IDLE;
						done_d             = 1'b1;
						res_d.status       = ghc_pkg::ST_OK;
						res_d.slot_index   = slot_ext[ghc_pkg::SLOT_W-1:0];
						res_d.pool_offset  = probe_entry.offset;
						res_d.entry_bytes  = probe_entry.size;
						res_d.entry_width  = probe_entry.width;
						res_d.entry_height = probe_entry.height;
					end else begin
						cur_d   = cur_q + IDX_W'(1);
						probe_d = probe_q + PRB_W'(1);
					end
				end
			end

			S_CLEAR: begin
				// Drop one slot per cycle; the rest of the entry is don't-care
				ram_we           = 1'b1;
				ram_waddr        = clr_idx_q;
				ram_wentry.valid = 1'b0;
				clr_idx_d        = clr_idx_q + IDX_W'(1);
				if (clr_idx_q == LAST_SLOT) begin
					state_d      = S_IDLE;
					done_d       = clr_report_q;
					clr_report_d = 1'b0;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state; reset starts the clearing sweep with no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			clr_report_q <= 1'b0;
			pool_fill_q  <= '0;
			done_q       <= 1'b0;
			probe_q      <= '0;
		end else begin
			state_q      <= state_d;
			clr_idx_q    <= clr_idx_d;
			clr_report_q <= clr_report_d;
			pool_fill_q  <= pool_fill_d;
			done_q       <= done_d;
			probe_q      <= probe_d;
		end
	end

	// Payload: hold the command on transfer, advance the walk, latch results
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			key_q    <= code_point;
			bytes_q  <= bitmap_bytes;
			width_q  <= glyph_width;
			height_q <= glyph_height;
		end
		cur_q <= cur_d;
		res_q <= res_d;
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = res_q.status;
	assign slot_index   = res_q.slot_index;
	assign pool_offset  = res_q.pool_offset;
	assign entry_bytes  = res_q.entry_bytes;
	assign entry_width  = res_q.entry_width;
	assign entry_height = res_q.entry_height;

endmodule

`default_nettype wire

### src/ghc_ram.sv
// ---------------------------------------------------------------------------
// ghc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ghc_ram #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### src/ghc_checker.sv
// ---------------------------------------------------------------------------
// ghc_checker
// Port-level checks on the glyph cache command and result behaviour.
// ---------------------------------------------------------------------------
`default_nettype none

`include "glyph_hash_cache_defines.svh"

module ghc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic [ghc_pkg::OP_W-1:0]       op,
	input wire logic                           done,
	input wire logic [ghc_pkg::STATUS_W-1:0]   status,
	input wire logic [ghc_pkg::SLOT_W-1:0]     slot_index,
	input wire logic [ghc_pkg::POOL_W-1:0]     pool_offset,
	input wire logic [ghc_pkg::BYTES_W-1:0]    entry_bytes,
	input wire logic [ghc_pkg::DIM_W-1:0]      entry_width,
	input wire logic [ghc_pkg::DIM_W-1:0]      entry_height
);

	// A transferred command either occupies the block or answers at once
	`GHC_ASSERT_NXT(a_cmd_taken, start && !busy, busy || done, "command neither started nor answered")

	// A clear always sweeps before it answers
	`GHC_ASSERT_NXT(a_clear_sweeps, start && !busy && op == ghc_pkg::OP_CLEAR, busy && !done, "clear answered without a sweep")

	// Results come only once the block is free again
	`GHC_ASSERT_IMP(a_done_idle, done, !busy && ($past(busy) || $past(start)), "result while busy or unprompted")

	// Failed commands report no entry
	`GHC_ASSERT_IMP(a_fail_zero, done && status != ghc_pkg::ST_OK, slot_index == '0 && pool_offset == '0 && entry_bytes == '0 && entry_width == '0 && entry_height == '0, "failed result carries entry data")

endmodule

bind glyph_hash_cache ghc_checker u_ghc_checker (.*);

`default_nettype wire
